@@ src/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared constants, codes and types of the Modbus RTU reply checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int MAX_REGS    = 16;
    localparam int STORE_DEPTH = 5 + 2 * MAX_REGS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int FUNC_W     = 7;
    localparam int REGCNT_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CRC_W      = 16;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CRC       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXCEPTION = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADCOUNT  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = 2'd2;

    // exception codes after which a retry cannot help
    localparam logic [BYTE_W-1:0] EXC_ILLEGAL_FUNC  = 8'd1;
    localparam logic [BYTE_W-1:0] EXC_ILLEGAL_ADDR  = 8'd2;
    localparam logic [BYTE_W-1:0] EXC_ILLEGAL_VALUE = 8'd3;
    localparam logic [BYTE_W-1:0] EXC_GW_PATH       = 8'd10;

    localparam logic [BYTE_W-1:0] EXC_FLAG = 8'h80;

    typedef struct packed {
        logic init;
        logic load;
        logic step;
    } t_crc_ctl;

endpackage

@@ src/mrc_in_if.sv @@
// ----------------------------------------------------------------------------
// mrc_in_if
// Input channel: received bytes, timeout and start events.
// ----------------------------------------------------------------------------
interface mrc_in_if;
    logic                        valid;
    logic                        ready;
    logic [mrc_pkg::KIND_W-1:0]  kind;
    logic [mrc_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, kind, rx_byte, input ready);
    modport sink   (input valid, kind, rx_byte, output ready);
endinterface

@@ src/mrc_out_if.sv @@
// ----------------------------------------------------------------------------
// mrc_out_if
// Result channel: status, frame byte, last marker and retry flag.
// ----------------------------------------------------------------------------
interface mrc_out_if;
    logic                          valid;
    logic                          ready;
    logic [mrc_pkg::STATUS_W-1:0]  status;
    logic [mrc_pkg::BYTE_W-1:0]    data_byte;
    logic                          last;
    logic                          retry_allowed;

    modport source (output valid, status, data_byte, last, retry_allowed, input ready);
    modport sink   (input valid, status, data_byte, last, retry_allowed, output ready);
endinterface

@@ src/mrc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// mrc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mrc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mrc_pkg::CFG_IDX_W-1:0]  index;
    logic [mrc_pkg::BYTE_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/modbus_rtu_reply_checker.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_reply_checker
// Buffers and checks one read-registers reply, then streams it out or
// reports a single status item.
// ----------------------------------------------------------------------------
//  channel  dir  carries                                   accepted when
//  i_cfg    in   index, data                               valid & ready (ready=1)
//  i_in     in   kind, rx_byte                             valid & ready
//  o_out    out  status, data_byte, last, retry_allowed    valid & ready
//
//  A byte item goes through accept, a bit-serial CRC fold (S_FOLD), then decision.
//  Start and timeout items are decided on acceptance; a status item is then handed over through S_PUT.
//  A good reply streams out byte by byte (buffer read, then output); a stalled sink holds the output step.
//  Reset is synchronous; the buffer needs no clearing pass.
//  The output register is free-running: a stalled sink only holds up the
//  next item that has a result to hand over.
// ----------------------------------------------------------------------------
module modbus_rtu_reply_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrc_cfg_if.sink     i_cfg,
    mrc_in_if.sink      i_in,
    mrc_out_if.source   o_out
);

    localparam int CNT_W  = mrc_pkg::CNT_W;
    localparam int ADDR_W = mrc_pkg::ADDR_W;
    localparam int BW     = mrc_pkg::BYTE_W;
    localparam int SW     = mrc_pkg::STATUS_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_FOLD    = 6'b000010,
        S_POST    = 6'b000100,
        S_PUT     = 6'b001000,
        S_EMIT_RD = 6'b010000,
        S_EMIT_WR = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic                          r_recv, n_recv;
    logic [CNT_W-1:0]              r_bytes, n_bytes;
    logic [CNT_W-1:0]              r_len, n_len;
    logic [2:0]                    r_bit, n_bit;
    logic [BW-1:0]                 r_b0, n_b0;
    logic [BW-1:0]                 r_b1, n_b1;
    logic [BW-1:0]                 r_b2, n_b2;
    logic [ADDR_W-1:0]             r_ptr, n_ptr;
    logic [ADDR_W-1:0]             r_end, n_end;
    logic [SW-1:0]                 r_put_status, n_put_status;
    logic [BW-1:0]                 r_put_data, n_put_data;
    logic                          r_put_retry, n_put_retry;

    logic                          r_out_valid, n_out_valid;
    logic [SW-1:0]                 r_out_status, n_out_status;
    logic [BW-1:0]                 r_out_data, n_out_data;
    logic                          r_out_last, n_out_last;
    logic                          r_out_retry, n_out_retry;

    logic [BW-1:0]                 r_slave;
    logic [mrc_pkg::FUNC_W-1:0]    r_func;
    logic [mrc_pkg::REGCNT_W-1:0]  r_regs;

    logic                          in_acc;
    logic                          out_free;
    logic                          out_load;
    logic                          count_ok;
    logic [CNT_W-1:0]              len_norm;
    logic [CNT_W-1:0]              len_eff;
    logic [CNT_W-1:0]              len_m5;
    logic                          permanent;

    mrc_pkg::t_crc_ctl             crc_ctl;
    logic                          crc_zero;
    logic                          wr_en;
    logic                          rd_en;
    logic [BW-1:0]                 rd_data;

    mrc_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_byte  (i_in.rx_byte),
        .o_zero  (crc_zero)
    );

    mrc_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_bytes[ADDR_W-1:0]),
        .i_wr_data (i_in.rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data)
    );

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave <= 8'd1;
            r_func  <= 7'd3;
            r_regs  <= 5'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mrc_pkg::CFG_SLAVE_ADDR: r_slave <= i_cfg.data;
                mrc_pkg::CFG_FUNC_CODE:  r_func  <= i_cfg.data[mrc_pkg::FUNC_W-1:0];
                mrc_pkg::CFG_REG_COUNT:  r_regs  <= i_cfg.data[mrc_pkg::REGCNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign count_ok = (r_regs != '0)
                   && (r_regs <= mrc_pkg::REGCNT_W'(mrc_pkg::MAX_REGS));
    assign len_norm = CNT_W'(5) + CNT_W'({r_regs, 1'b0});
    // length is fixed once the function byte is in
    assign len_eff  = (r_bytes == CNT_W'(2))
                    ? ((r_b1[7]) ? CNT_W'(5) : len_norm) : r_len;
    assign len_m5   = len_eff - CNT_W'(5);

    assign permanent = (r_b2 == mrc_pkg::EXC_ILLEGAL_FUNC)
                    || (r_b2 == mrc_pkg::EXC_ILLEGAL_ADDR)
                    || (r_b2 == mrc_pkg::EXC_ILLEGAL_VALUE)
                    || (r_b2 == mrc_pkg::EXC_GW_PATH);

    always_comb begin
        n_state      = r_state;
        n_recv       = r_recv;
        n_bytes      = r_bytes;
        n_len        = r_len;
        n_bit        = r_bit;
        n_b0         = r_b0;
        n_b1         = r_b1;
        n_b2         = r_b2;
        n_ptr        = r_ptr;
        n_end        = r_end;
        n_put_status = r_put_status;
        n_put_data   = r_put_data;
        n_put_retry  = r_put_retry;
        crc_ctl      = '0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        n_out_retry  = r_out_retry;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.kind)
                        mrc_pkg::KIND_START: begin
                            n_bytes      = '0;
                            n_len        = '0;
                            crc_ctl.init = 1'b1;
                            n_recv       = count_ok;
                            if (!count_ok) begin
                                n_put_status = mrc_pkg::ST_BADCOUNT;
                                n_put_data   = '0;
                                n_put_retry  = 1'b0;
                                n_state      = S_PUT;
                            end
                        end
                        mrc_pkg::KIND_TIMEOUT: begin
                            if (r_recv) begin
                                n_recv       = 1'b0;
                                n_put_status = mrc_pkg::ST_TIMEOUT;
                                n_put_data   = '0;
                                n_put_retry  = 1'b1;
                                n_state      = S_PUT;
                            end
                        end
                        mrc_pkg::KIND_BYTE: begin
                            if (r_recv) begin
                                wr_en        = (r_bytes < CNT_W'(mrc_pkg::STORE_DEPTH));
                                n_bytes      = r_bytes + CNT_W'(1);
                                crc_ctl.load = 1'b1;
                                n_bit        = '0;
                                if (r_bytes == CNT_W'(0)) n_b0 = i_in.rx_byte;
                                if (r_bytes == CNT_W'(1)) n_b1 = i_in.rx_byte;
                                if (r_bytes == CNT_W'(2)) n_b2 = i_in.rx_byte;
                                n_state      = S_FOLD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_FOLD: begin
                crc_ctl.step = 1'b1;
                n_bit        = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = S_POST;
                end
            end

            S_POST: begin
                n_state = S_IDLE;
                if (r_bytes == CNT_W'(2) && !r_b1[7] && !count_ok) begin
                    n_recv       = 1'b0;
                    n_put_status = mrc_pkg::ST_BADCOUNT;
                    n_put_data   = '0;
                    n_put_retry  = 1'b0;
                    n_state      = S_PUT;
                end else begin
                    n_len = len_eff;
                    if (len_eff != '0 && r_bytes >= len_eff) begin
                        n_recv       = 1'b0;
                        n_put_data   = '0;
                        n_put_retry  = 1'b1;
                        n_state      = S_PUT;
                        if (!crc_zero) begin
                            n_put_status = mrc_pkg::ST_CRC;
                        end else if (r_b0 != r_slave) begin
                            n_put_status = mrc_pkg::ST_MISMATCH;
                        end else if ((r_b1 & mrc_pkg::EXC_FLAG) != '0) begin
                            n_put_status = mrc_pkg::ST_EXCEPTION;
                            n_put_data   = r_b2;
                            n_put_retry  = !permanent;
                        end else if (r_b1 != {1'b0, r_func}) begin
                            n_put_status = mrc_pkg::ST_MISMATCH;
                        end else if (r_b2 != BW'(len_m5)) begin
                            n_put_status = mrc_pkg::ST_BADCOUNT;
                        end else begin
                            // address, function, then data bytes (count byte skipped)
                            n_ptr   = '0;
                            n_end   = ADDR_W'(len_eff - CNT_W'(3));
                            n_state = S_EMIT_RD;
                        end
                    end
                end
            end

            S_PUT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out_status = r_put_status;
                    n_out_data   = r_put_data;
                    n_out_last   = 1'b1;
                    n_out_retry  = r_put_retry;
                    n_state      = S_IDLE;
                end
            end

            S_EMIT_RD: begin
                rd_en   = 1'b1;
                n_state = S_EMIT_WR;
            end

            S_EMIT_WR: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out_status = mrc_pkg::ST_OK;
                    n_out_data   = rd_data;
                    n_out_last   = (r_ptr == r_end);
                    n_out_retry  = 1'b0;
                    if (r_ptr == r_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = (r_ptr == ADDR_W'(1)) ? ADDR_W'(3) : r_ptr + ADDR_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_recv      <= 1'b0;
            r_bytes     <= '0;
            r_len       <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_recv      <= n_recv;
            r_bytes     <= n_bytes;
            r_len       <= n_len;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0         <= n_b0;
        r_b1         <= n_b1;
        r_b2         <= n_b2;
        r_ptr        <= n_ptr;
        r_end        <= n_end;
        r_put_status <= n_put_status;
        r_put_data   <= n_put_data;
        r_put_retry  <= n_put_retry;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
        r_out_retry  <= n_out_retry;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.data_byte     = r_out_data;
    assign o_out.last          = r_out_last;
    assign o_out.retry_allowed = r_out_retry;

    // eighth CRC shift always hands over to the decision step
    a_fold_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD && r_bit == 3'd7) |=> (r_state == S_POST))
        else $error("CRC fold did not end after eight shifts");

    // byte counter never runs past the buffer
    a_bytes_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= CNT_W'(mrc_pkg::STORE_DEPTH))
        else $error("byte counter beyond buffer depth");

    // any failure status closes the reply
    a_fail_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != mrc_pkg::ST_OK) |-> r_out_last)
        else $error("status item not marked last");

    // a good reply never offers a retry
    a_ok_noretry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == mrc_pkg::ST_OK) |-> !r_out_retry)
        else $error("retry flag set on good data");

    // a new item is only taken when the previous one has been finished
    a_stream_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD || r_state == S_EMIT_WR) |-> !i_in.ready)
        else $error("input taken while streaming a reply");

endmodule

@@ src/mrc_crc.sv @@
// ----------------------------------------------------------------------------
// mrc_crc
// Bit-serial CRC-16 (reflected 0xA001): one shift per cycle while stepped.
// ----------------------------------------------------------------------------
module mrc_crc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mrc_pkg::t_crc_ctl           i_ctl,
    input  logic [mrc_pkg::BYTE_W-1:0]  i_byte,
    output logic                        o_zero
);

    logic [mrc_pkg::CRC_W-1:0] r_crc;
    logic [mrc_pkg::CRC_W-1:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = mrc_pkg::CRC_INIT;
        end else if (i_ctl.load) begin
            n_crc = r_crc ^ {{(mrc_pkg::CRC_W - mrc_pkg::BYTE_W){1'b0}}, i_byte};
        end else if (i_ctl.step) begin
            if (r_crc[0]) begin
                n_crc = (r_crc >> 1) ^ mrc_pkg::CRC_POLY;
            end else begin
                n_crc = r_crc >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= mrc_pkg::CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    // intact frame leaves the register at zero after its own CRC bytes
    assign o_zero = (r_crc == '0);

endmodule

@@ src/mrc_store.sv @@
// ----------------------------------------------------------------------------
// mrc_store
// Frame byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrc_store (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [mrc_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [mrc_pkg::BYTE_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [mrc_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [mrc_pkg::BYTE_W-1:0]  o_rd_data
);

    logic [mrc_pkg::BYTE_W-1:0] r_mem [mrc_pkg::STORE_DEPTH];
    logic [mrc_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
